[rtl/cvab_pkg.sv]
`default_nettype none

package cvab_pkg;

  localparam int MASK_SLOTS = 16;
  localparam int MASK_IDX_W = 4;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = CFG_IDX_W'(1);

  localparam logic [15:0] THRESHOLD_RESET = 16'd145;
  localparam logic [15:0] ACTIVE_RESET    = 16'hF00F;

  typedef struct packed {
    logic [3:0]  cell_index;
    logic [15:0] cell_voltage;
    logic        end_of_scan;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_cell;
    logic [15:0] cell_average;
    logic        scan_done;
    logic [3:0]  lowest_cell;
    logic [15:0] lowest_average;
    logic [15:0] discharge_mask;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_DIVGO,
    S_DIV,
    S_MIN,
    S_MASK,
    S_OUT
  } cvab_state_t;

endpackage

`default_nettype wire

[rtl/cell_voltage_average_balancer.sv]
`default_nettype none

// Windowed cell voltage averager with passive balancing decision.
// in channel: one reading beat per item (cell_index, cell_voltage, end_of_scan),
//   taken when in_valid is high and in_stall low. in_stall is high while an
//   item is in work and during the history clear after reset.
// out channel: exactly one result beat per item, held in an output register
//   until out_stall is low; the next item is taken while a result waits.
// cfg channel: cfg_ready is always high; index 0 balance threshold,
//   index 1 active cell mask, other indexes ignored. Write only when idle.
// Steps per item: accept, read the history memory (one port read per cycle),
//   divide by reciprocal multiply, then load the result. End of scan adds
//   one pass for the minimum and one for the discharge mask, each over the
//   min(NUM_CELLS,16) stored averages, one per cycle. A slot outside NUM_CELLS
//   skips the history read and the divide but still makes both passes on end
//   of scan. A stalled result holds the next item in its load cycle until
//   out_stall drops.
// Reset: registers return to defaults, averages and mask clear, and a clearing
//   pass writes zero to all min(NUM_CELLS,16) << max(1,clog2(WINDOW_LEN))
//   history entries (128 by default) before the first item is taken.
module cell_voltage_average_balancer
  import cvab_pkg::*;
#(
  parameter int NUM_CELLS  = 16,
  parameter int WINDOW_LEN = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int USED_CELLS = (NUM_CELLS < MASK_SLOTS) ? NUM_CELLS : MASK_SLOTS;
  localparam int CELL_W     = $clog2(USED_CELLS);
  localparam int PW         = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int JW         = $clog2(WINDOW_LEN + 1);
  localparam int ADDR_W     = CELL_W + PW;
  localparam int DEPTH      = USED_CELLS << PW;
  localparam int SUM_W      = 16 + $clog2(WINDOW_LEN);

  cvab_state_t state, state_next;

  logic [15:0] threshold;
  logic [15:0] active;

  logic [15:0] hist [DEPTH];
  logic [15:0] rd_data;
  logic        rd_vld;

  logic [PW-1:0]     pos  [USED_CELLS];
  logic [15:0]       avgs [USED_CELLS];
  logic [ADDR_W-1:0] clr_addr;

  logic [3:0]       cur_index;
  logic             cur_ok;
  logic             cur_eos;
  logic [JW-1:0]    j;
  logic [SUM_W-1:0] acc;
  logic [15:0]      cur_avg;

  logic [CELL_W-1:0] sidx;
  logic              found;
  logic [3:0]        lo_cell;
  logic [15:0]       lo_avg;
  logic [15:0]       mask_acc;
  logic [15:0]       balance_bits;

  logic              accept;
  logic              in_ok;
  logic [CELL_W-1:0] in_cell;
  logic [CELL_W-1:0] cur_cell;
  logic              clr_last;
  logic              sum_last;
  logic              scan_last;
  logic              slot_on;
  logic [15:0]       s_avg;
  logic              mask_hit;
  logic [15:0]       mask_bit;
  logic              out_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_q;

  cvab_div #(
    .NUM_W  (SUM_W),
    .DIVISOR(WINDOW_LEN)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .done    (div_done),
    .quotient(div_q)
  );

  assign cfg_ready = 1'b1;
  assign in_cell   = in_data.cell_index[CELL_W-1:0];
  assign in_ok     = (32'(in_data.cell_index) < USED_CELLS);
  assign cur_cell  = cur_index[CELL_W-1:0];
  assign clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign sum_last  = (j == JW'(WINDOW_LEN));
  assign scan_last = (sidx == CELL_W'(USED_CELLS - 1));
  assign slot_on   = active[MASK_IDX_W'(sidx)];
  assign s_avg     = avgs[sidx];
  assign rd_addr   = {cur_cell, j[PW-1:0]};
  assign mask_hit  = slot_on && found && ((s_avg - lo_avg) > threshold);
  assign mask_bit  = mask_hit ? (16'd1 << MASK_IDX_W'(sidx)) : 16'd0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_ok)               state_next = S_SUM;
          else if (in_data.end_of_scan)     state_next = S_MIN;
          else                              state_next = S_OUT;
        end
      end
      S_SUM:   if (sum_last) state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = cur_eos ? S_MIN : S_OUT;
      S_MIN:   if (scan_last) state_next = S_MASK;
      S_MASK:  if (scan_last) state_next = S_OUT;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        in_stall  = 1'b0;
        accept    = in_valid;
        mem_we    = in_valid && in_ok;
        mem_waddr = {in_cell, pos[in_cell]};
        mem_wdata = in_data.cell_voltage;
      end
      S_DIVGO: div_start = 1'b1;
      S_OUT:   out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    rd_data <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      active    <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_THRESHOLD) threshold <= cfg_data;
      if (cfg_index == CFG_ACTIVE)    active    <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      j            <= '0;
      rd_vld       <= 1'b0;
      sidx         <= '0;
      found        <= 1'b0;
      balance_bits <= '0;
      for (int c = 0; c < USED_CELLS; c++) begin
        pos[c]  <= '0;
        avgs[c] <= '0;
      end
    end else begin
      rd_vld <= (state == S_SUM) && !sum_last;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        S_IDLE: begin
          j     <= '0;
          sidx  <= '0;
          found <= 1'b0;
          if (accept && in_ok) begin
            pos[in_cell] <= (pos[in_cell] == PW'(WINDOW_LEN - 1)) ?
                            '0 : pos[in_cell] + PW'(1);
          end
        end
        S_SUM: begin
          if (!sum_last) j <= j + JW'(1);
        end
        S_DIV: begin
          if (div_done) avgs[cur_cell] <= div_q[15:0];
        end
        S_MIN: begin
          if (slot_on && (!found || s_avg <= lo_avg)) found <= 1'b1;
          sidx <= scan_last ? '0 : sidx + CELL_W'(1);
        end
        S_MASK: begin
          sidx <= sidx + CELL_W'(1);
          // last slot's bit joins the accumulated mask on the way in
          if (scan_last) balance_bits <= mask_acc | mask_bit;
        end
        default: ;
      endcase
    end
  end

  // item payload and search results
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_index <= in_data.cell_index;
      cur_ok    <= in_ok;
      cur_eos   <= in_data.end_of_scan;
      acc       <= '0;
      cur_avg   <= '0;
      lo_cell   <= '0;
      lo_avg    <= '0;
      mask_acc  <= '0;
    end else begin
      if (rd_vld) acc <= acc + SUM_W'(rd_data);
      if (state == S_DIV && div_done && cur_ok) cur_avg <= div_q[15:0];
      if (state == S_MIN && slot_on && (!found || s_avg <= lo_avg)) begin
        lo_cell <= MASK_IDX_W'(sidx);
        lo_avg  <= s_avg;
      end
      if (state == S_MASK) mask_acc <= mask_acc | mask_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_cell       <= cur_index;
      out_data.cell_average   <= cur_avg;
      out_data.scan_done      <= cur_eos;
      out_data.lowest_cell    <= cur_eos ? lo_cell : 4'd0;
      out_data.lowest_average <= cur_eos ? lo_avg : 16'd0;
      out_data.discharge_mask <= balance_bits;
    end
  end

endmodule

`default_nettype wire

[rtl/cvab_div.sv]
`default_nettype none

// floor division by a fixed divisor as a reciprocal multiply; the product is
// registered, so done is high in the cycle after start
module cvab_div #(
  parameter int NUM_W   = 19,
  parameter int DIVISOR = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  // exact for any dividend below 2**NUM_W: the rounding error of the
  // reciprocal stays under 1/DIVISOR
  localparam int     SHIFT   = NUM_W + $clog2(DIVISOR);
  localparam int     RECIP_W = NUM_W + 1;
  localparam int     PROD_W  = NUM_W + RECIP_W;
  localparam longint RECIP   =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [PROD_W-1:0] prod;

  assign quotient = NUM_W'(prod >> SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(dividend) * PROD_W'(RECIP_C);
    end
  end

endmodule

`default_nettype wire

[tb/cell_voltage_average_balancer_tb.sv]
`timescale 1ns / 1ps

module cell_voltage_average_balancer_tb;
  import cvab_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int WIN_LEN   = 8;
  localparam int SETTLE_CYCLES = 70;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_ACTIVE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  cell_voltage_average_balancer #(
    .NUM_CELLS (NUM_SLOTS),
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the block's state and registers
  logic [15:0] window_mem [NUM_SLOTS][WIN_LEN];
  logic [2:0]  ring_ptr   [NUM_SLOTS];
  logic [15:0] avg_mem    [NUM_SLOTS];
  logic [15:0] held_mask;
  logic [15:0] thr_reg = THRESHOLD_RESET;
  logic [15:0] act_reg = ACTIVE_RESET;

  in_t  pending_readings[$];
  out_t expected_results[$];
  out_t want_res;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit drain_hold     = 1'b0;

  int n_errors    = 0;
  int n_readings  = 0;
  int n_results   = 0;
  int n_scans     = 0;
  int n_balanced  = 0;
  int n_cfg_writes = 0;

  initial begin
    for (int c = 0; c < NUM_SLOTS; c++) begin
      for (int j = 0; j < WIN_LEN; j++) window_mem[c][j] = '0;
      ring_ptr[c] = '0;
      avg_mem[c]  = '0;
    end
    held_mask = '0;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  // windowed average update plus the end-of-scan lowest-cell search and discharge mask
  function automatic out_t predict_reading(in_t rd);
    out_t        res;
    logic [18:0] total;
    logic        found;
    logic [3:0]  lo_cell;
    logic [15:0] lo_avg;
    logic [15:0] mask;
    logic [16:0] excess;
    res = '0;
    window_mem[rd.cell_index][ring_ptr[rd.cell_index]] = rd.cell_voltage;
    ring_ptr[rd.cell_index] = ring_ptr[rd.cell_index] + 1'b1;
    total = '0;
    for (int j = 0; j < WIN_LEN; j++) total = total + window_mem[rd.cell_index][j];
    avg_mem[rd.cell_index] = 16'(total / WIN_LEN);
    res.out_cell     = rd.cell_index;
    res.cell_average = avg_mem[rd.cell_index];
    if (rd.end_of_scan) begin
      found   = 1'b0;
      lo_cell = '0;
      lo_avg  = '0;
      mask    = '0;
      // <= so that a later cell wins a tie
      for (int c = 0; c < NUM_SLOTS; c++) begin
        if (act_reg[c] && (!found || avg_mem[c] <= lo_avg)) begin
          lo_cell = 4'(c);
          lo_avg  = avg_mem[c];
          found   = 1'b1;
        end
      end
      if (found) begin
        for (int c = 0; c < NUM_SLOTS; c++) begin
          excess = {1'b0, avg_mem[c]} - {1'b0, lo_avg};
          if (act_reg[c] && excess > {1'b0, thr_reg}) mask[c] = 1'b1;
        end
      end
      held_mask          = mask;
      res.scan_done      = 1'b1;
      res.lowest_cell    = lo_cell;
      res.lowest_average = lo_avg;
      n_scans++;
      if (mask != 0) n_balanced++;
    end
    res.discharge_mask = held_mask;
    n_readings++;
    return res;
  endfunction

  // driver: reading beats from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_reading(pending_readings.pop_front()));
      if (!in_valid || !in_stall) begin
        if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
        if (pending_readings.size() != 0 && !drain_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_readings[0];
          // now and then hold off until the block has drained
          if ($urandom_range(0, 299) == 0) drain_hold = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result for cell %0d with nothing expected",
                                    out_data.out_cell));
        end else begin
          want_res = expected_results.pop_front();
          check_field("out_cell", out_data.out_cell, want_res.out_cell);
          check_field("cell_average", out_data.cell_average, want_res.cell_average);
          check_field("scan_done", out_data.scan_done, want_res.scan_done);
          check_field("lowest_cell", out_data.lowest_cell, want_res.lowest_cell);
          check_field("lowest_average", out_data.lowest_average,
                      want_res.lowest_average);
          check_field("discharge_mask", out_data.discharge_mask,
                      want_res.discharge_mask);
        end
        n_results++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_reg = data;
    else if (idx == CFG_ACTIVE) act_reg = data;
    n_cfg_writes++;
  endtask

  task automatic queue_reading(int slot, int volt, bit eos);
    in_t rd;
    rd.cell_index   = 4'(slot);
    rd.cell_voltage = 16'(volt);
    rd.end_of_scan  = eos;
    pending_readings.push_back(rd);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_readings.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // mostly scans over the cells with readings clustered near the threshold,
  // the rest single stray readings
  task automatic gen_readings(int n_items);
    int          made;
    int          base;
    int          spread;
    int          last;
    logic [15:0] incl;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_reading($urandom_range(0, 15), $urandom_range(0, 65535),
                      $urandom_range(0, 3) == 0);
        made++;
      end else begin
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 2 * thr_reg + 64);
        if (spread > 65535) spread = 65535;
        base = $urandom_range(0, 65535 - spread);
        last = -1;
        for (int c = 0; c < NUM_SLOTS; c++) begin
          incl[c] = ($urandom_range(0, 7) != 0);
          if (incl[c]) last = c;
        end
        for (int c = 0; c < NUM_SLOTS; c++) begin
          if (incl[c]) begin
            queue_reading(c, base + $urandom_range(0, spread), c == last);
            made++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // history clear pass runs with in_stall high
    @(negedge clk);
    while (in_stall) @(negedge clk);

    set_idling(34, 80);

    // full-scale reading, ties among zero averages, inactive slot
    queue_reading(0, 16'hFFFF, 1'b0);
    queue_reading(15, 0, 1'b1);
    queue_reading(5, 16'hFFFF, 1'b1);
    for (int i = 0; i < WIN_LEN; i++) queue_reading(1, 16'hFFFF, i == WIN_LEN - 1);
    wait_drained();

    // excess exactly at the threshold, then one above
    cfg_write(CFG_THRESHOLD, 16'd8191);
    queue_reading(3, 0, 1'b1);
    wait_drained();
    cfg_write(CFG_THRESHOLD, 16'd8190);
    queue_reading(3, 0, 1'b1);
    wait_drained();

    // no active cell; a write to an unused index must change nothing
    cfg_write(CFG_ACTIVE, 16'h0000);
    cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
              16'($urandom_range(0, 65535)));
    queue_reading(9, 16'h5555, 1'b1);
    wait_drained();

    cfg_write(CFG_ACTIVE, 16'hFFFF);
    cfg_write(CFG_THRESHOLD, 16'h0000);
    queue_reading(7, 0, 1'b1);
    wait_drained();
    cfg_write(CFG_THRESHOLD, 16'hFFFF);
    queue_reading(6, 16'hAAAA, 1'b1);
    wait_drained();
    cfg_write(CFG_ACTIVE, 16'h0002);
    queue_reading(2, 0, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       set_idling(34, 80);
        1:       set_idling(80, 34);
        default: set_idling(0, 0);
      endcase
      case (p)
        0: begin
          cfg_write(CFG_THRESHOLD, THRESHOLD_RESET);
          cfg_write(CFG_ACTIVE, ACTIVE_RESET);
        end
        1: begin
          cfg_write(CFG_THRESHOLD, 16'h0000);
          cfg_write(CFG_ACTIVE, 16'hFFFF);
        end
        2: begin
          cfg_write(CFG_THRESHOLD, 16'hFFFF);
          cfg_write(CFG_ACTIVE, 16'($urandom_range(0, 65535)));
        end
        3: begin
          cfg_write(CFG_THRESHOLD, 16'($urandom_range(0, 400)));
          cfg_write(CFG_ACTIVE, 16'($urandom_range(0, 65535)));
        end
        4: begin
          cfg_write(CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
          cfg_write(CFG_ACTIVE, 16'h8001);
        end
        default: begin
          cfg_write(CFG_THRESHOLD, 16'($urandom_range(0, 300)));
          cfg_write(CFG_ACTIVE, 16'hFFFF);
        end
      endcase
      cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                16'($urandom_range(0, 65535)));
      gen_readings(285);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d readings, %0d end-of-scan searches (%0d with cells to discharge),",
             n_readings, n_scans, n_balanced);
    $display("%0d register writes, %0d results checked, %0d errors",
             n_cfg_writes, n_results, n_errors);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timed out with %0d readings pending, %0d results outstanding",
             pending_readings.size(), expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
